/* design/lrcc_pkg.sv */
package lrcc_pkg;

  localparam logic [31:0] CrcInit     = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
  localparam logic [31:0] MaxLenReset = 32'd10485760;
  localparam logic [31:0] CountMax    = 32'hFFFF_FFFF;
  localparam logic [1:0]  LastHdrByte = 2'd3;

  typedef enum logic [2:0] {
    PH_LEN = 3'b001,
    PH_CRC = 3'b010,
    PH_PAY = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    ST_GOOD  = 2'd0,
    ST_BAD   = 2'd1,
    ST_BIG   = 2'd2,
    ST_TRUNC = 2'd3
  } status_e;

  // reflected crc-32, one byte, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* design/log_record_crc_checker.sv */
// Checks a log byte stream of length-prefixed records (4-byte little-endian
// length, 4-byte little-endian crc-32, payload). One byte is taken per clock
// cycle unless input is held off, with a combinational crc update; a result
// is registered into the output register in the cycle after the byte that
// ends a record (or the end_of_log byte), and input is held off only while
// that register is full and not taken. Status: good, crc mismatch, oversized (length above
// max_record_length, dropped right after the header), or truncated at end of
// log. After an end_of_log byte all parse state and the drop count return to
// reset; max_record_length keeps its value. No clearing pass is needed.
module log_record_crc_checker import lrcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_log_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] record_length_o,
  output logic [31:0] computed_crc_o,
  output logic [31:0] dropped_count_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  phase_e      phase_q, phase_d, phase_nx;
  logic [1:0]  idx_q, idx_d, idx_nx;
  logic [31:0] len_q, len_d, len_nx;
  logic [31:0] scrc_q, scrc_d, scrc_nx;
  logic [31:0] rcrc_q, rcrc_d, rcrc_nx;
  logic [31:0] rem_q, rem_d, rem_nx;
  logic [31:0] drop_q, drop_d, drop_nx;
  logic [31:0] max_len_q;

  logic        out_valid_q;
  status_e     out_status_q;
  logic [31:0] out_len_q, out_crc_q, out_drop_q;

  logic        in_xfer;
  logic        emit, restart;
  status_e     res_status;
  logic [31:0] res_len, res_crc;
  logic [31:0] len_ins, scrc_ins, crc_new, drop_bump;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign drop_bump  = (drop_q != CountMax) ? drop_q + 32'd1 : drop_q;

  always_comb begin
    len_ins  = len_q;
    scrc_ins = scrc_q;
    len_ins[{idx_q, 3'b000} +: 8]  = data_byte_i;
    scrc_ins[{idx_q, 3'b000} +: 8] = data_byte_i;
    crc_new  = crc_byte(rcrc_q, data_byte_i);

    phase_nx   = phase_q;
    idx_nx     = idx_q;
    len_nx     = len_q;
    scrc_nx    = scrc_q;
    rcrc_nx    = rcrc_q;
    rem_nx     = rem_q;
    drop_nx    = drop_q;
    emit       = 1'b0;
    restart    = 1'b0;
    res_status = ST_GOOD;
    res_len    = len_q;
    res_crc    = '0;

    unique case (phase_q)
      PH_CRC: begin
        scrc_nx = scrc_ins;
        if (idx_q == LastHdrByte) begin
          idx_nx = '0;
          if (len_q > max_len_q) begin
            drop_nx    = drop_bump;
            emit       = 1'b1;
            res_status = ST_BIG;
            restart    = 1'b1;
          end else if (len_q == '0) begin
            // empty payload: computed crc is zero
            emit    = 1'b1;
            restart = 1'b1;
            if (scrc_ins != '0) begin
              res_status = ST_BAD;
              drop_nx    = drop_bump;
            end
          end else begin
            phase_nx = PH_PAY;
            rcrc_nx  = CrcInit;
            rem_nx   = len_q;
          end
        end else begin
          idx_nx = idx_q + 2'd1;
        end
      end
      PH_PAY: begin
        rcrc_nx = crc_new;
        rem_nx  = (rem_q != '0) ? rem_q - 32'd1 : '0;
        if (rem_nx == '0) begin
          emit    = 1'b1;
          restart = 1'b1;
          res_crc = ~crc_new;
          if (~crc_new != scrc_q) begin
            res_status = ST_BAD;
            drop_nx    = drop_bump;
          end
        end
      end
      default: begin
        phase_nx = PH_LEN;
        len_nx   = len_ins;
        if (idx_q == LastHdrByte) begin
          idx_nx   = '0;
          phase_nx = PH_CRC;
          scrc_nx  = '0;
        end else begin
          idx_nx = idx_q + 2'd1;
        end
      end
    endcase

    // end of log inside a record
    if (end_of_log_i && !emit) begin
      emit       = 1'b1;
      res_status = ST_TRUNC;
      res_len    = (phase_nx == PH_LEN) ? '0 : len_nx;
      res_crc    = (phase_nx == PH_PAY) ? ~rcrc_nx : '0;
    end

    phase_d = phase_nx;
    idx_d   = idx_nx;
    len_d   = len_nx;
    scrc_d  = scrc_nx;
    rcrc_d  = rcrc_nx;
    rem_d   = rem_nx;
    drop_d  = end_of_log_i ? '0 : drop_nx;
    if (restart || end_of_log_i) begin
      phase_d = PH_LEN;
      idx_d   = '0;
      len_d   = '0;
      scrc_d  = '0;
      rcrc_d  = CrcInit;
      rem_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEN;
      idx_q     <= '0;
      len_q     <= '0;
      scrc_q    <= '0;
      rcrc_q    <= CrcInit;
      rem_q     <= '0;
      drop_q    <= '0;
      max_len_q <= MaxLenReset;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (in_xfer) begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        len_q   <= len_d;
        scrc_q  <= scrc_d;
        rcrc_q  <= rcrc_d;
        rem_q   <= rem_d;
        drop_q  <= drop_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      out_status_q <= res_status;
      out_len_q    <= res_len;
      out_crc_q    <= res_crc;
      out_drop_q   <= drop_nx;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign record_length_o = out_len_q;
  assign computed_crc_o  = out_crc_q;
  assign dropped_count_o = out_drop_q;

  // every end_of_log transfer yields a result
  a_eol_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && end_of_log_i) |=> out_valid_o)
    else $error("no result after end of log");

  // end of log returns the parser and drop count to reset
  a_eol_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && end_of_log_i) |=> (phase_q == PH_LEN && idx_q == '0 && drop_q == '0))
    else $error("state not cleared after end of log");

  // oversized records carry no crc
  a_big_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_BIG) |-> (computed_crc_o == '0))
    else $error("oversized result with nonzero crc");

  // payload phase always has bytes left
  a_pay_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAY) |-> (rem_q != '0))
    else $error("payload phase with no bytes remaining");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import lrcc_pkg::*;

  localparam int CycleLimit = 400000;

  typedef struct packed {
    status_e     status;
    logic [31:0] rec_len;
    logic [31:0] crc;
    logic [31:0] drops;
  } record_verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = 8'd0;
  logic        end_of_log = 1'b0;
  logic        out_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = 32'd0;

  logic        in_ready;
  logic        out_valid;
  logic [1:0]  status;
  logic [31:0] record_length;
  logic [31:0] computed_crc;
  logic [31:0] dropped_count;

  // parser state mirrored from the block
  phase_e      parse_phase;
  logic [1:0]  hdr_idx;
  logic [31:0] len_reg;
  logic [31:0] crc_stored;
  logic [31:0] crc_run;
  logic [31:0] remaining;
  logic [31:0] drops;
  logic [31:0] max_len;

  record_verdict_t verdict_q[$];
  logic [7:0]      frame_q[$];

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int sink_hold = 0;
  int mismatches = 0;
  int results_seen = 0;
  int bytes_sent = 0;
  int cycle_count = 0;

  log_record_crc_checker u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .data_byte_i     (data_byte),
    .end_of_log_i    (end_of_log),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .record_length_o (record_length),
    .computed_crc_o  (computed_crc),
    .dropped_count_o (dropped_count),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // bit-serial form of the reflected crc-32 update
  function automatic logic [31:0] crc32_shift_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0] ^ b[i]}});
    end
    return c;
  endfunction

  task automatic restart_parse();
    parse_phase = PH_LEN;
    hdr_idx     = 2'd0;
    len_reg     = 32'd0;
    crc_stored  = 32'd0;
    crc_run     = CrcInit;
    remaining   = 32'd0;
  endtask

  task automatic bump_drops();
    if (drops != CountMax) drops++;
  endtask

  task automatic push_verdict(input status_e st, input logic [31:0] len,
                              input logic [31:0] crc);
    record_verdict_t v;
    v.status  = st;
    v.rec_len = len;
    v.crc     = crc;
    v.drops   = drops;
    verdict_q = {verdict_q, v};
  endtask

  task automatic close_record();
    if (~crc_run != crc_stored) begin
      bump_drops();
      push_verdict(ST_BAD, len_reg, ~crc_run);
    end else begin
      push_verdict(ST_GOOD, len_reg, ~crc_run);
    end
  endtask

  task automatic track_log_byte(input logic [7:0] b, input logic eol);
    bit produced;
    produced = 1'b0;
    case (parse_phase)
      PH_CRC: begin
        crc_stored[hdr_idx*8 +: 8] = b;
        if (hdr_idx == LastHdrByte) begin
          hdr_idx = 2'd0;
          if (len_reg > max_len) begin
            bump_drops();
            push_verdict(ST_BIG, len_reg, 32'd0);
            produced = 1'b1;
            restart_parse();
          end else if (len_reg == 32'd0) begin
            crc_run = CrcInit;
            close_record();
            produced = 1'b1;
            restart_parse();
          end else begin
            parse_phase = PH_PAY;
            crc_run     = CrcInit;
            remaining   = len_reg;
          end
        end else begin
          hdr_idx++;
        end
      end
      PH_PAY: begin
        crc_run = crc32_shift_byte(crc_run, b);
        if (remaining != 32'd0) remaining--;
        if (remaining == 32'd0) begin
          close_record();
          produced = 1'b1;
          restart_parse();
        end
      end
      default: begin
        parse_phase = PH_LEN;
        len_reg[hdr_idx*8 +: 8] = b;
        if (hdr_idx == LastHdrByte) begin
          hdr_idx     = 2'd0;
          parse_phase = PH_CRC;
          crc_stored  = 32'd0;
        end else begin
          hdr_idx++;
        end
      end
    endcase
    if (eol) begin
      if (!produced) begin
        push_verdict(ST_TRUNC, (parse_phase == PH_LEN) ? 32'd0 : len_reg,
                     (parse_phase == PH_PAY) ? ~crc_run : 32'd0);
      end
      drops = 32'd0;
      restart_parse();
    end
  endtask

  task automatic check_verdict();
    record_verdict_t want;
    results_seen++;
    if (verdict_q.size() == 0) begin
      $error("unexpected result: status %0d length %h", status, record_length);
      mismatches++;
    end else begin
      want = verdict_q.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d actual %0d", want.status, status);
        mismatches++;
      end
      if (record_length !== want.rec_len) begin
        $error("record_length: expected %h actual %h", want.rec_len, record_length);
        mismatches++;
      end
      if (computed_crc !== want.crc) begin
        $error("computed_crc: expected %h actual %h", want.crc, computed_crc);
        mismatches++;
      end
      if (dropped_count !== want.drops) begin
        $error("dropped_count: expected %h actual %h", want.drops, dropped_count);
        mismatches++;
      end
    end
  endtask

  // result side: check each transfer, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_verdict();
    if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold--;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eol);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    end_of_log <= eol;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    track_log_byte(b, eol);
  endtask

  // header plus payload; fill < 0 means random payload bytes
  task automatic append_record(input logic [31:0] len_field, input int n_pay,
                               input bit bad_crc, input int fill);
    logic [7:0]  pay[$];
    logic [31:0] crc;
    crc = CrcInit;
    for (int i = 0; i < n_pay; i++) begin
      pay = {pay, ((fill < 0) ? 8'($urandom_range(255)) : 8'(fill))};
      crc = crc32_shift_byte(crc, pay[i]);
    end
    crc = ~crc;
    if (bad_crc) crc ^= 32'h1 << $urandom_range(31);
    for (int i = 0; i < 4; i++) frame_q = {frame_q, len_field[8*i +: 8]};
    for (int i = 0; i < 4; i++) frame_q = {frame_q, crc[8*i +: 8]};
    foreach (pay[i]) frame_q = {frame_q, pay[i]};
  endtask

  // cut >= 0 stops the log early at that byte
  task automatic flush_log(input bit end_log, input int cut);
    int n;
    n = (cut >= 0 && cut < frame_q.size()) ? cut + 1 : frame_q.size();
    for (int i = 0; i < n; i++) send_item(frame_q[i], end_log && (i == n - 1));
    frame_q.delete();
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [31:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    max_len = v;
  endtask

  task automatic test_record_basics();
    append_record(32'd0, 0, 1'b0, -1);
    append_record(32'd0, 0, 1'b1, -1);
    append_record(32'd1, 1, 1'b0, 8'h00);
    append_record(32'd4, 4, 1'b0, 8'hFF);
    append_record(32'd5, 5, 1'b1, -1);
    append_record(MaxLenReset + 32'd1, 0, 1'b0, -1);
    append_record(32'hFFFF_FFFF, 0, 1'b0, -1);
    append_record(32'd2, 2, 1'b0, -1);
    // end of log on a completing byte gives one result, not truncated
    flush_log(1'b1, -1);
    append_record(32'd3, 3, 1'b1, -1);
    flush_log(1'b0, -1);
    drain_results();
  endtask

  task automatic test_truncation();
    int cuts[6] = '{0, 2, 4, 7, 8, 12};
    foreach (cuts[i]) begin
      append_record(32'd6, 6, 1'($urandom_range(1)), -1);
      flush_log(1'b1, cuts[i]);
    end
    // length right at the limit goes to payload, then the log ends
    append_record(MaxLenReset, 2, 1'b0, -1);
    flush_log(1'b1, -1);
    drain_results();
  endtask

  task automatic test_limit_extremes();
    write_max_length(32'd0);
    append_record(32'd0, 0, 1'b0, -1);
    append_record(32'd1, 0, 1'b0, -1);
    append_record(32'd0, 0, 1'b1, -1);
    flush_log(1'b1, -1);
    write_max_length(32'hFFFF_FFFF);
    append_record(32'hFFFF_FFFF, 3, 1'b0, -1);
    flush_log(1'b1, -1);
    append_record(32'd9, 9, 1'b0, -1);
    flush_log(1'b0, -1);
    write_max_length(MaxLenReset);
  endtask

  task automatic test_output_stall();
    write_max_length(MaxLenReset);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    sink_hold     = 300;
    repeat (8) append_record(32'd2, 2, 1'($urandom_range(1)), -1);
    flush_log(1'b0, -1);
    drain_results();
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_bytes);
    int          start_bytes;
    int          start_res;
    int          n;
    int          r;
    logic [31:0] ovr;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    start_bytes   = bytes_sent;
    start_res     = results_seen;
    while (bytes_sent - start_bytes < n_bytes || results_seen - start_res < 20) begin
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(4))
          0: write_max_length(32'd0);
          1: write_max_length(32'hFFFF_FFFF);
          2: write_max_length(MaxLenReset);
          3: write_max_length(32'($urandom_range(1, 16)));
          default: write_max_length($urandom());
        endcase
      end
      if ($urandom_range(99) < 10) begin
        // raw noise, then close the log
        repeat ($urandom_range(1, 20)) frame_q = {frame_q, 8'($urandom_range(255))};
        flush_log(1'b1, -1);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          r = $urandom_range(99);
          if (r < 15 && max_len != 32'hFFFF_FFFF) begin
            ovr = $urandom();
            if (ovr <= max_len || $urandom_range(1)) ovr = max_len + 32'd1;
            append_record(ovr, 0, 1'b0, -1);
          end else begin
            n = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
            if (max_len < n) n = max_len;
            append_record(32'(n), n, r < 40, -1);
          end
        end
        r = $urandom_range(99);
        if (r < 60) flush_log(1'b1, -1);
        else if (r < 85) flush_log(1'b1, $urandom_range(0, frame_q.size() - 1));
        else flush_log(1'b0, -1);
      end
    end
    drain_results();
  endtask

  initial begin
    max_len = MaxLenReset;
    drops   = 32'd0;
    restart_parse();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_record_basics();
    test_truncation();
    test_limit_extremes();
    test_output_stall();
    test_random_traffic(15, 87, 200);
    test_random_traffic(87, 15, 200);
    test_random_traffic(0, 0, 200);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
